// File: hdl/assert_macros.svh
// Assertion macros shared by the positioner RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/thp_pkg.sv
// Shared types and codes for the two-axis hall positioner.
// Used by thp_axis and two_axis_hall_positioner_top; no dependencies.
package thp_pkg;

  // Field widths, and the hall step counter's saturation limits
  localparam int COUNT_BITS  = 22;
  localparam int TARGET_BITS = 21;
  localparam int FACTOR_BITS = 13;
  localparam int ANGLE_BITS  = 8;
  localparam int CFG_BITS    = 21;

  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_PULSE = 2'd1;
  localparam logic [1:0] KIND_CMD   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Command codes
  localparam logic [1:0] CMD_GOTO_ANGLE = 2'd0;
  localparam logic [1:0] CMD_HOME       = 2'd1;
  localparam logic [1:0] CMD_HALT       = 2'd2;

  // Axis status codes
  localparam logic [2:0] ST_SET_ANGLE    = 3'd0;
  localparam logic [2:0] ST_HOMING       = 3'd1;
  localparam logic [2:0] ST_STOP_PENDING = 3'd2;
  localparam logic [2:0] ST_DONE         = 3'd3;
  localparam logic [2:0] ST_ILLEGAL_END  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW     = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_VERT_FACTOR = 2'd0;
  localparam logic [1:0] CFG_HORZ_FACTOR = 2'd1;
  localparam logic [1:0] CFG_MAX_STEPS   = 2'd2;

  // Per-axis state
  typedef struct packed {
    logic signed [COUNT_BITS-1:0] count;
    logic [TARGET_BITS-1:0]       target;
    logic [2:0]                   status;
    logic                         motor_on;
    logic                         forward;
  } axis_state_t;

  // One request as seen by one axis
  typedef struct packed {
    logic [1:0]             kind;
    logic                   hit;
    logic [1:0]             command;
    logic [ANGLE_BITS-1:0]  angle;
    logic [FACTOR_BITS-1:0] factor;
    logic [TARGET_BITS-1:0] max_steps;
    logic                   end_low;
  } axis_req_t;

endpackage

// File: hdl/two_axis_hall_positioner_top.sv
// Two-axis hall positioner: request register, per-axis update, state/result.
// Depends on thp_pkg, thp_axis and assert_macros.svh.
//
// Usage:
//   Requests (kind, axis, command, angle, end switch levels) enter on the
//   in_valid/in_ready channel. Each request yields exactly one result: both
//   axes' drive, direction, status and hall count after that request, on the
//   out_valid/out_ready channel.
//   An accepted request passes through the request register, then the
//   axis state registers, which also serve as the result register.
//   Throughput: one request per cycle while results are taken; the update
//   of both axes is a single combinational pass through an 8x13 multiply
//   per axis and the compares. A stalled receiver holds the result; one
//   more request waits in the request register, after which in_ready drops
//   until the result is taken.
//   Configuration (factors, max_steps) is written through cfg_wr_en,
//   cfg_index, cfg_data while no request is in flight.
//   Reset (rst, synchronous) empties both stages, clears counts, targets,
//   drive and direction, sets both axes to homing, factors to 1 and
//   max_steps to its full range.
`include "assert_macros.svh"

module two_axis_hall_positioner_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [thp_pkg::CFG_BITS-1:0]          cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            kind,
  input  logic                                  axis,
  input  logic [1:0]                            command,
  input  logic [7:0]                            angle,
  input  logic                                  vert_end_low,
  input  logic                                  horz_end_low,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  vert_drive,
  output logic                                  vert_forward,
  output logic                                  horz_drive,
  output logic                                  horz_forward,
  output logic [2:0]                            vert_status,
  output logic [2:0]                            horz_status,
  output logic signed [thp_pkg::COUNT_BITS-1:0] vert_count,
  output logic signed [thp_pkg::COUNT_BITS-1:0] horz_count
);
  import thp_pkg::*;

  // Configuration registers
  logic [FACTOR_BITS-1:0] vert_factor;
  logic [FACTOR_BITS-1:0] horz_factor;
  logic [TARGET_BITS-1:0] max_steps;

  // Request register
  logic                  req_valid;
  logic [1:0]            req_kind;
  logic                  req_axis;
  logic [1:0]            req_command;
  logic [ANGLE_BITS-1:0] req_angle;
  logic                  req_vert_end_low;
  logic                  req_horz_end_low;

  // Axis state, doubling as the result register
  axis_state_t vert_state;
  axis_state_t horz_state;
  axis_state_t vert_state_next;
  axis_state_t horz_state_next;
  axis_req_t   vert_req;
  axis_req_t   horz_req;

  logic advance;

  // Request moves into the state when the result slot is free or being taken
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_factor <= FACTOR_BITS'(1);
      horz_factor <= FACTOR_BITS'(1);
      max_steps   <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VERT_FACTOR: vert_factor <= cfg_data[FACTOR_BITS-1:0];
        CFG_HORZ_FACTOR: horz_factor <= cfg_data[FACTOR_BITS-1:0];
        CFG_MAX_STEPS:   max_steps   <= cfg_data[TARGET_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind         <= kind;
      req_axis         <= axis;
      req_command      <= command;
      req_angle        <= angle;
      req_vert_end_low <= vert_end_low;
      req_horz_end_low <= horz_end_low;
    end
  end

  // Per-axis view of the request
  always_comb begin
    vert_req.kind      = req_kind;
    vert_req.hit       = !req_axis;
    vert_req.command   = req_command;
    vert_req.angle     = req_angle;
    vert_req.factor    = vert_factor;
    vert_req.max_steps = max_steps;
    vert_req.end_low   = req_vert_end_low;

    horz_req.kind      = req_kind;
    horz_req.hit       = req_axis;
    horz_req.command   = req_command;
    horz_req.angle     = req_angle;
    horz_req.factor    = horz_factor;
    horz_req.max_steps = max_steps;
    horz_req.end_low   = req_horz_end_low;
  end

  thp_axis u_vert (
    .cur (vert_state),
    .req (vert_req),
    .nxt (vert_state_next)
  );

  thp_axis u_horz (
    .cur (horz_state),
    .req (horz_req),
    .nxt (horz_state_next)
  );

  // Axis state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_state <= '{count: '0, target: '0, status: ST_HOMING, motor_on: 1'b0,
                      forward: 1'b0};
      horz_state <= '{count: '0, target: '0, status: ST_HOMING, motor_on: 1'b0,
                      forward: 1'b0};
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        vert_state <= vert_state_next;
        horz_state <= horz_state_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  assign vert_drive   = vert_state.motor_on;
  assign vert_forward = vert_state.forward;
  assign vert_status  = vert_state.status;
  assign vert_count   = vert_state.count;
  assign horz_drive   = horz_state.motor_on;
  assign horz_forward = horz_state.forward;
  assign horz_status  = horz_state.status;
  assign horz_count   = horz_state.count;

  // A moved request always leaves a result behind
  `ASSERT_NEXT(a_advance_result, clk, rst, advance, out_valid)

  // Motor only runs while driving to a target, homing or awaiting stop
  `ASSERT_ALWAYS(a_vert_drive_status, clk, rst,
    !vert_drive || vert_status == ST_SET_ANGLE || vert_status == ST_HOMING ||
    vert_status == ST_STOP_PENDING)

  // A homing tick with the switch low ends at count zero, motor off
  `ASSERT_NEXT(a_vert_home_clears, clk, rst,
    advance && req_kind == KIND_TICK && vert_state.status == ST_HOMING &&
    req_vert_end_low,
    vert_count == '0 && !vert_drive && vert_status == ST_DONE)

endmodule

// File: hdl/thp_axis.sv
// Next-state logic of one positioner axis for one request.
// Depends on thp_pkg.
module thp_axis (
  input  thp_pkg::axis_state_t cur,
  input  thp_pkg::axis_req_t   req,
  output thp_pkg::axis_state_t nxt
);
  import thp_pkg::*;

  localparam int CMP_BITS = ((COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS) + 1;

  logic signed [CMP_BITS-1:0] cnt_ext;
  logic signed [CMP_BITS-1:0] tgt_ext;
  logic signed [CMP_BITS-1:0] nxt_cnt_ext;
  logic signed [CMP_BITS-1:0] max_ext;
  logic [TARGET_BITS-1:0]     product;

  // Wide signed views for the count/target and count/limit compares
  assign cnt_ext     = CMP_BITS'(cur.count);
  assign tgt_ext     = $signed(CMP_BITS'(cur.target));
  assign max_ext     = $signed(CMP_BITS'(req.max_steps));

  // 8 x 13 target product fits the target width exactly
  assign product = TARGET_BITS'(req.angle) * TARGET_BITS'(req.factor);

  always_comb begin
    nxt = cur;
    case (req.kind)
      // Tick: act on current status
      KIND_TICK: begin
        case (cur.status)
          ST_SET_ANGLE: begin
            if (tgt_ext > cnt_ext) begin
              nxt.forward  = 1'b1;
              nxt.motor_on = 1'b1;
            end else if (tgt_ext < cnt_ext) begin
              nxt.forward  = 1'b0;
              nxt.motor_on = 1'b1;
            end else begin
              nxt.motor_on = 1'b0;
              nxt.status   = ST_DONE;
            end
          end
          ST_HOMING: begin
            nxt.forward  = 1'b0;
            nxt.motor_on = !req.end_low;
            if (req.end_low) begin
              nxt.count  = '0;
              nxt.status = ST_DONE;
            end
          end
          ST_STOP_PENDING: begin
            nxt.motor_on = 1'b0;
            nxt.status   = ST_DONE;
          end
          default: ;
        endcase
      end
      // Hall pulse: saturating count in current direction
      KIND_PULSE: begin
        if (req.hit) begin
          if (cur.forward) begin
            if (cur.count != COUNT_MAX) nxt.count = cur.count + COUNT_ONE;
          end else begin
            if (cur.count != COUNT_MIN) nxt.count = cur.count - COUNT_ONE;
          end
        end
      end
      // Command write
      KIND_CMD: begin
        if (req.hit) begin
          case (req.command)
            CMD_GOTO_ANGLE: begin
              nxt.target = product;
              nxt.status = ST_SET_ANGLE;
            end
            CMD_HOME: nxt.status = ST_HOMING;
            CMD_HALT: nxt.status = ST_STOP_PENDING;
            default:  ;
          endcase
        end
      end
      // End switch change: low switch while backing up outside homing is an error
      KIND_END: begin
        if (req.end_low && !cur.forward && cur.status != ST_HOMING) begin
          nxt.motor_on = 1'b0;
          nxt.status   = ST_ILLEGAL_END;
        end
      end
      default: ;
    endcase

    // Overflow check on the updated count
    nxt_cnt_ext = CMP_BITS'(nxt.count);
    if (nxt_cnt_ext > max_ext) begin
      nxt.motor_on = 1'b0;
      nxt.status   = ST_OVERFLOW;
    end
  end

endmodule
